### rtl/xedt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xedt_pkg
// Shared types, character constants and entity tables for the entity decoder
// and whitespace trimmer.
// ----------------------------------------------------------------------------
package xedt_pkg;

    // Named entities, longest spelling is five characters including ';'.
    localparam int NUM_ENT      = 6;
    localparam int NAME_LEN     = 5;
    localparam int PREFIX_DEPTH = 4;

    // Decoupling queue between decoder and trimmer.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] WS_SPACE = 2'd0;
    localparam logic [1:0] WS_TAB   = 2'd1;
    localparam logic [1:0] WS_CR    = 2'd2;
    localparam logic [1:0] WS_LF    = 2'd3;

    localparam logic [7:0] ENT_NAME [NUM_ENT][NAME_LEN] = '{
        '{"l", "t", ";", CH_NUL, CH_NUL},
        '{"g", "t", ";", CH_NUL, CH_NUL},
        '{"a", "m", "p", ";", CH_NUL},
        '{"q", "u", "o", "t", ";"},
        '{"a", "p", "o", "s", ";"},
        '{"n", "b", "s", "p", ";"}
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5};
    localparam logic [7:0] ENT_VAL [NUM_ENT] = '{"<", ">", "&", "\"", "'", " "};

    // One decoded word passed from decoder to trimmer.
    typedef struct packed {
        logic [7:0] data;
        logic       err;       // literal '&' of a rejected entity
        logic       end_step;  // produced by the input byte that closes the run
        logic       is_end;    // run terminator, carries no byte
    } t_token;

    // One result word on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       run_last;
        logic       err;
        logic       ovf;
    } t_result;

    typedef struct packed {
        logic       complete;
        logic       partial;
        logic [7:0] value;
    } t_match;

    typedef struct packed {
        logic       hit;
        logic [1:0] code;
    } t_ws;

    // Match a collected prefix plus one new character against the entity names.
    function automatic t_match ent_match(input logic [PREFIX_DEPTH-1:0][7:0] pfx,
                                         input logic [2:0] len, input logic [7:0] c);
        t_match m;
        logic   ok;
        m = '0;
        for (int i = 0; i < NUM_ENT; i++) begin
            ok = ({1'b0, len} + 4'd1) <= {1'b0, ENT_LEN[i]};
            for (int j = 0; j < PREFIX_DEPTH; j++) begin
                if (3'(j) < len && ENT_NAME[i][j] != pfx[j]) begin
                    ok = 1'b0;
                end
            end
            if (ok && ENT_NAME[i][len] == c) begin
                if (({1'b0, len} + 4'd1) == {1'b0, ENT_LEN[i]}) begin
                    m.complete = 1'b1;
                    m.value    = ENT_VAL[i];
                end else begin
                    m.partial = 1'b1;
                end
            end
        end
        return m;
    endfunction

    function automatic t_ws ws_classify(input logic [7:0] c);
        t_ws w;
        w.hit = 1'b1;
        case (c)
            CH_SPACE: w.code = WS_SPACE;
            CH_TAB:   w.code = WS_TAB;
            CH_CR:    w.code = WS_CR;
            CH_LF:    w.code = WS_LF;
            default: begin
                w.hit  = 1'b0;
                w.code = WS_SPACE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] ws_char(input logic [1:0] code);
        logic [7:0] c;
        unique case (code)
            WS_SPACE: c = CH_SPACE;
            WS_TAB:   c = CH_TAB;
            WS_CR:    c = CH_CR;
            WS_LF:    c = CH_LF;
            default:  c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage

### rtl/xedt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xedt_front
// Entity decoder: accepts raw bytes and pushes decoded words, one per cycle
// while the queue is not full, into the decoupling queue.
// ----------------------------------------------------------------------------
module xedt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_text_byte,
    input  logic              i_run_end,
    input  logic              i_q_full,
    output logic              o_push,
    output xedt_pkg::t_token  o_token
);
    import xedt_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_ABN_AMP  = 9'b000000010,
        ST_ABN_PRE  = 9'b000000100,
        ST_NUM_VAL  = 9'b000001000,
        ST_NUM_AMP  = 9'b000010000,
        ST_NUM_HASH = 9'b000100000,
        ST_RESUME   = 9'b001000000,
        ST_TAIL     = 9'b010000000,
        ST_FINAL    = 9'b100000000
    } t_fstate;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_NAME   = 3'b010,
        MODE_NUM    = 3'b100
    } t_mode;

    t_fstate                       r_st, n_st;
    t_mode                         r_mode, n_mode;
    logic [PREFIX_DEPTH-1:0][7:0]  r_prefix, n_prefix;
    logic [2:0]                    r_len, n_len;
    logic [1:0]                    r_idx, n_idx;
    logic [7:0]                    r_val, n_val;
    logic                          r_ds, n_ds;
    logic                          r_redo, n_redo;
    logic                          r_in_end, n_in_end;
    logic [7:0]                    r_c, n_c;
    logic                          r_e, n_e;

    t_match      m;
    t_fstate     after_char;
    t_fstate     after_abn;
    logic        is_digit;
    logic [11:0] prod;

    assign m          = ent_match(r_prefix, r_len, i_text_byte);
    assign is_digit   = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
    assign prod       = {4'b0, r_val} * 12'd10;
    assign after_char = i_run_end ? ST_TAIL : ST_IDLE;
    assign after_abn  = r_redo ? ST_RESUME : ((r_in_end || r_e) ? ST_FINAL : ST_IDLE);
    assign o_in_stall = (r_st != ST_IDLE) || i_q_full;

    always_comb begin
        n_st     = r_st;
        n_mode   = r_mode;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_idx    = r_idx;
        n_val    = r_val;
        n_ds     = r_ds;
        n_redo   = r_redo;
        n_in_end = r_in_end;
        n_c      = r_c;
        n_e      = r_e;
        o_push   = 1'b0;
        o_token.data     = CH_NUL;
        o_token.err      = 1'b0;
        o_token.end_step = (r_st == ST_IDLE) ? i_run_end : r_e;
        o_token.is_end   = 1'b0;

        if (!i_q_full) begin
            unique case (r_st)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        n_c      = i_text_byte;
                        n_e      = i_run_end;
                        n_redo   = 1'b0;
                        n_in_end = 1'b0;
                        n_st     = after_char;
                        unique case (r_mode)
                            MODE_NAME: begin
                                if (r_len == 3'd0 && i_text_byte == CH_HASH) begin
                                    n_mode = MODE_NUM;
                                    n_val  = 8'd0;
                                    n_ds   = 1'b0;
                                end else if (m.complete) begin
                                    o_push       = 1'b1;
                                    o_token.data = m.value;
                                    n_mode       = MODE_NORMAL;
                                    n_len        = 3'd0;
                                end else if (m.partial) begin
                                    n_prefix[r_len[1:0]] = i_text_byte;
                                    n_len                = r_len + 3'd1;
                                end else begin
                                    // not an entity: replay '&' and prefix, then the byte
                                    n_mode = MODE_NORMAL;
                                    n_redo = 1'b1;
                                    n_st   = ST_ABN_AMP;
                                end
                            end
                            MODE_NUM: begin
                                if (is_digit) begin
                                    n_val = prod[7:0] + {4'b0, 4'(i_text_byte - CH_ZERO)};
                                    n_ds  = 1'b1;
                                end else if (r_ds && i_text_byte == CH_SEMI) begin
                                    n_mode = MODE_NORMAL;
                                    n_st   = ST_NUM_VAL;
                                end else begin
                                    n_mode = MODE_NORMAL;
                                    n_redo = 1'b1;
                                    n_st   = r_ds ? ST_NUM_VAL : ST_NUM_AMP;
                                end
                            end
                            default: begin
                                if (i_text_byte == CH_AMP) begin
                                    n_mode = MODE_NAME;
                                    n_len  = 3'd0;
                                end else begin
                                    o_push       = 1'b1;
                                    o_token.data = i_text_byte;
                                end
                            end
                        endcase
                    end
                end
                ST_ABN_AMP: begin
                    o_push       = 1'b1;
                    o_token.data = CH_AMP;
                    o_token.err  = 1'b1;
                    n_idx        = 2'd0;
                    n_st         = (r_len != 3'd0) ? ST_ABN_PRE : after_abn;
                end
                ST_ABN_PRE: begin
                    o_push       = 1'b1;
                    o_token.data = r_prefix[r_idx];
                    n_idx        = r_idx + 2'd1;
                    if ({1'b0, r_idx} == r_len - 3'd1) begin
                        n_st = after_abn;
                    end
                end
                ST_NUM_VAL: begin
                    o_push       = 1'b1;
                    o_token.data = r_val;
                    n_st         = after_abn;
                end
                ST_NUM_AMP: begin
                    o_push       = 1'b1;
                    o_token.data = CH_AMP;
                    o_token.err  = 1'b1;
                    n_st         = ST_NUM_HASH;
                end
                ST_NUM_HASH: begin
                    o_push       = 1'b1;
                    o_token.data = CH_HASH;
                    n_st         = after_abn;
                end
                ST_RESUME: begin
                    n_redo = 1'b0;
                    if (r_c == CH_AMP) begin
                        n_mode = MODE_NAME;
                        n_len  = 3'd0;
                    end else begin
                        o_push       = 1'b1;
                        o_token.data = r_c;
                    end
                    n_st = r_e ? ST_TAIL : ST_IDLE;
                end
                ST_TAIL: begin
                    n_in_end = 1'b1;
                    n_redo   = 1'b0;
                    unique case (r_mode)
                        MODE_NAME: begin
                            n_mode = MODE_NORMAL;
                            n_st   = ST_ABN_AMP;
                        end
                        MODE_NUM: begin
                            n_mode = MODE_NORMAL;
                            n_st   = r_ds ? ST_NUM_VAL : ST_NUM_AMP;
                        end
                        default: n_st = ST_FINAL;
                    endcase
                end
                ST_FINAL: begin
                    o_push           = 1'b1;
                    o_token.end_step = 1'b1;
                    o_token.is_end   = 1'b1;
                    n_mode           = MODE_NORMAL;
                    n_len            = 3'd0;
                    n_val            = 8'd0;
                    n_ds             = 1'b0;
                    n_in_end         = 1'b0;
                    n_st             = ST_IDLE;
                end
                default: n_st = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_mode   <= MODE_NORMAL;
            r_len    <= 3'd0;
            r_idx    <= 2'd0;
            r_val    <= 8'd0;
            r_ds     <= 1'b0;
            r_redo   <= 1'b0;
            r_in_end <= 1'b0;
            r_e      <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_val    <= n_val;
            r_ds     <= n_ds;
            r_redo   <= n_redo;
            r_in_end <= n_in_end;
            r_e      <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prefix <= n_prefix;
        r_c      <= n_c;
    end

endmodule

### rtl/xedt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xedt_queue
// Short FIFO of decoded words between decoder and trimmer.
// ----------------------------------------------------------------------------
module xedt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xedt_pkg::t_token  i_token,
    output logic              o_full,
    input  logic              i_pop,
    output xedt_pkg::t_token  o_head,
    output logic              o_empty
);
    import xedt_pkg::*;

    t_token             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + Q_PTR_W'(1) : r_wr;
        n_rd  = do_pop ? r_rd + Q_PTR_W'(1) : r_rd;
        n_cnt = r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

endmodule

### rtl/xedt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xedt_back
// Whitespace trimmer: drops leading whitespace, holds interior whitespace in
// a circular buffer, and drives the output register.
// ----------------------------------------------------------------------------
module xedt_back #(
    parameter int HOLD_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xedt_pkg::t_token  i_head,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output xedt_pkg::t_result o_result
);
    import xedt_pkg::*;

    localparam int PTR_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

    logic [1:0]       r_hold [HOLD_DEPTH];
    logic [1:0]       r_rd;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_started, n_started;
    t_result          r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    t_result          r_out, n_out;
    logic             r_out_v, n_out_v;

    logic    out_free;
    logic    emit;
    t_result emit_res;
    logic    out_push;
    t_result out_res;
    logic    wr_en;
    t_ws     ws;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(HOLD_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign ws          = ws_classify(i_head.data);
    assign out_free    = !r_out_v || !i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_started = r_started;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        emit      = 1'b0;
        emit_res  = '0;
        out_push  = 1'b0;
        out_res   = '0;

        if (!i_q_empty && out_free) begin
            if (i_head.is_end) begin
                // close the run: tag the last result, or send an empty one
                out_push = 1'b1;
                if (r_pend_v) begin
                    out_res = r_pend;
                end
                out_res.run_last = 1'b1;
                n_pend_v  = 1'b0;
                n_head    = '0;
                n_tail    = '0;
                n_count   = '0;
                n_started = 1'b0;
                o_pop     = 1'b1;
            end else if (ws.hit) begin
                o_pop = 1'b1;
                if (r_started) begin
                    wr_en  = 1'b1;
                    n_tail = ptr_inc(r_tail);
                    if (r_count == CNT_W'(HOLD_DEPTH)) begin
                        // buffer full: release the oldest untrimmed
                        emit                = 1'b1;
                        emit_res.data       = ws_char(r_rd);
                        emit_res.byte_valid = 1'b1;
                        emit_res.ovf        = 1'b1;
                        n_head              = ptr_inc(r_head);
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end else if (r_count != '0) begin
                // held whitespace turned out interior: drain it first
                emit                = 1'b1;
                emit_res.data       = ws_char(r_rd);
                emit_res.byte_valid = 1'b1;
                n_head              = ptr_inc(r_head);
                n_count             = r_count - CNT_W'(1);
            end else begin
                emit                = 1'b1;
                emit_res.data       = i_head.data;
                emit_res.byte_valid = 1'b1;
                emit_res.err        = i_head.err;
                n_started           = 1'b1;
                o_pop               = 1'b1;
            end
        end

        // Within the closing step, keep one result back so the run end can tag it.
        if (emit) begin
            if (i_head.end_step) begin
                n_pend   = emit_res;
                n_pend_v = 1'b1;
                out_push = r_pend_v;
                out_res  = r_pend;
            end else begin
                out_push = 1'b1;
                out_res  = emit_res;
            end
        end

        n_out_v = r_out_v;
        n_out   = r_out;
        if (out_free) begin
            n_out_v = out_push;
            if (out_push) begin
                n_out = out_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_started <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_started <= n_started;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // Hold buffer; the read port tracks the next head, with write bypass.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hold[r_tail] <= ws.code;
        end
        if (wr_en && r_tail == n_head) begin
            r_rd <= ws.code;
        end else begin
            r_rd <= r_hold[n_head];
        end
    end

endmodule

### rtl/xml_entity_decode_trim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decode_trim
// Streaming XML character-entity decoder with whitespace trimming.
// ----------------------------------------------------------------------------
// Feed text one byte per word with i_run_end on the last byte of each run.
// The block decodes &lt; &gt; &amp; &quot; &apos; &nbsp; (nbsp becomes a
// space) and decimal &#N; references (value mod 256, ';' optional), then
// trims space, tab, CR and LF from both ends of the decoded run. Every run
// closes with exactly one word that has o_run_last set; if the closing byte
// produced nothing, that word is empty (o_byte_valid low). A rejected entity
// comes out literally, its '&' flagged by o_entity_error. Interior whitespace
// waits in a HOLD_DEPTH-entry buffer until a visible byte confirms it; if the
// buffer fills, the oldest entry is sent with o_trim_overflow set.
//
// Timing: the decoder takes a plain byte per cycle unless the queue is full;
// a named entity completed by its ';' adds no stall. A numeric reference
// closed by ';' stalls the input while its value is sent. A byte that breaks
// an entity stalls it while each replayed character is sent (the '&' and
// up to four prefix bytes, '&' and '#', or the value of an unterminated
// reference) and while the breaking byte is taken up again. The closing
// byte of a run is followed by the tail and final steps (the final step
// only, if it is the ';' of a numeric reference), on top of the replay of
// any entity it leaves open. Decoded words cross a four-entry queue, and
// the input stalls while it is full; the trimmer sends one result per cycle
// while the output is not stalled, so a visible byte after held whitespace
// waits for each held byte; ordinary text sustains one byte per cycle.
// ----------------------------------------------------------------------------
module xml_entity_decode_trim #(
    parameter int HOLD_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_run_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_entity_error,
    output logic       o_trim_overflow
);
    import xedt_pkg::*;

    // decoder -> queue
    logic    front_push;
    t_token  front_token;
    logic    q_full;
    // queue -> trimmer
    t_token  q_head;
    logic    q_empty;
    logic    back_pop;
    t_result result;

    // Front: classify each byte, track entity state, emit decoded words.
    xedt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_text_byte (i_text_byte),
        .i_run_end   (i_run_end),
        .i_q_full    (q_full),
        .o_push      (front_push),
        .o_token     (front_token)
    );

    // Decouple decoder bursts from trimmer drain cycles.
    xedt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_token (front_token),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // Back: trim whitespace, tag run end, hold the output register.
    xedt_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_empty   (q_empty),
        .o_pop       (back_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_out_byte      = result.data;
    assign o_byte_valid    = result.byte_valid;
    assign o_run_last      = result.run_last;
    assign o_entity_error  = result.err;
    assign o_trim_overflow = result.ovf;

endmodule
